// File: rtl/core/hefr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hefr_pkg;

    // Frame store sizing
    localparam int FRAME_BYTES_DEF = 16;
    localparam int STORE_DEPTH     = 11;   // only offsets 0..10 are ever decoded
    localparam int BUTTONS         = 16;

    // Frame lengths, end code included
    localparam int FRAME_LEN_BUTTON = 12;
    localparam int FRAME_LEN_TOUCH  = 10;
    localparam int FRAME_LEN_STATE  = 5;

    localparam logic [7:0] STATE_ON_CHAR = 8'h31;  // '1'

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    localparam logic [7:0] END_CODE_RST          = 8'd10;
    localparam logic [7:0] CLICK_CODE_RST        = 8'd67;
    localparam logic [7:0] DOUBLE_CLICK_CODE_RST = 8'd68;
    localparam logic [7:0] PRESS_START_CODE_RST  = 8'd76;
    localparam logic [7:0] PRESS_END_CODE_RST    = 8'd77;
    localparam logic [7:0] TOUCH_CODE_RST        = 8'd84;
    localparam logic [7:0] BUTTON_STATE_CODE_RST = 8'd66;

    localparam logic [CFG_IDX_W-1:0] REG_END_CODE          = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CLICK_CODE        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_CLICK_CODE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_START_CODE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_END_CODE    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TOUCH_CODE        = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BUTTON_STATE_CODE = 3'd6;

    typedef enum logic [2:0] {
        KIND_NONE         = 3'd0,
        KIND_CLICK        = 3'd1,
        KIND_DOUBLE_CLICK = 3'd2,
        KIND_PRESS_START  = 3'd3,
        KIND_PRESS_END    = 3'd4,
        KIND_TOUCH        = 3'd5,
        KIND_BUTTON_STATE = 3'd6
    } t_event_kind;

    typedef struct packed {
        logic       vld;
        logic [3:0] val;
    } t_hex_digit;

    function automatic t_hex_digit hex_digit(input logic [7:0] c);
        t_hex_digit d;
        d.vld = 1'b1;
        d.val = 4'd0;
        if (c inside {[8'h30:8'h39]}) begin
            d.val = c[3:0];
        end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
            d.val = c[3:0] + 4'd9;
        end else begin
            d.vld = 1'b0;
        end
        return d;
    endfunction

    // Digits up to the first non-hex character
    function automatic logic [7:0] hex_field2(input logic [7:0] c0, input logic [7:0] c1);
        t_hex_digit d0;
        t_hex_digit d1;
        logic [7:0] r;
        d0 = hex_digit(c0);
        d1 = hex_digit(c1);
        if (!d0.vld) begin
            r = 8'h00;
        end else if (!d1.vld) begin
            r = {4'h0, d0.val};
        end else begin
            r = {d0.val, d1.val};
        end
        return r;
    endfunction

    function automatic logic [15:0] hex_field4(input logic [7:0] c0, input logic [7:0] c1,
                                               input logic [7:0] c2, input logic [7:0] c3);
        t_hex_digit d0;
        t_hex_digit d1;
        t_hex_digit d2;
        t_hex_digit d3;
        logic [15:0] r;
        d0 = hex_digit(c0);
        d1 = hex_digit(c1);
        d2 = hex_digit(c2);
        d3 = hex_digit(c3);
        if (!d0.vld) begin
            r = 16'h0000;
        end else if (!d1.vld) begin
            r = {12'h000, d0.val};
        end else if (!d2.vld) begin
            r = {8'h00, d0.val, d1.val};
        end else if (!d3.vld) begin
            r = {4'h0, d0.val, d1.val, d2.val};
        end else begin
            r = {d0.val, d1.val, d2.val, d3.val};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/hefr_rx_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface hefr_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

// File: rtl/core/hefr_evt_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface hefr_evt_if;
    import hefr_pkg::*;

    logic        valid;
    logic        ready;
    t_event_kind event_kind;
    logic [7:0]  btn_id;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [15:0] button_mask;
    logic        index_error;

    modport source (output valid, output event_kind, output btn_id, output pos_x,
                    output pos_y, output button_mask, output index_error, input ready);
    modport sink   (input valid, input event_kind, input btn_id, input pos_x,
                    input pos_y, input button_mask, input index_error, output ready);
endinterface

`default_nettype wire

// File: rtl/core/hex_event_frame_receiver_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Handshake          Payload
// -------   ---  -----------------  ------------------------------------------------
// i_rx      in   valid/ready        rx_byte[7:0]
// o_evt     out  valid/ready        event_kind, btn_id, pos_x, pos_y,
//                                   button_mask, index_error
// cfg       in   i_cfg_we (no wait) i_cfg_index[2:0], i_cfg_data[7:0]
//
// One request in, one result out. Throughput is one request per cycle while the result is
// not stalled; a request is taken into the input register, then its result into the result
// register. Decode is fixed-position over a register frame store, so it is combinational.
// Reset (synchronous, active low) clears the write index, held values, mask and
// restores the default type codes; frame store contents are not cleared.
// A stalled result holds; the input register, if empty, can take one more request meanwhile.

module hex_event_frame_receiver_top #(
    parameter int FRAME_BYTES = hefr_pkg::FRAME_BYTES_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [hefr_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [hefr_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    hefr_rx_if.sink                          i_rx,
    hefr_evt_if.source                       o_evt
);
    import hefr_pkg::*;

    localparam int IW = $clog2(FRAME_BYTES);
    localparam int SW = $clog2(STORE_DEPTH);

    localparam logic [IW-1:0] LAST_IDX   = IW'(FRAME_BYTES - 1);
    localparam logic [IW-1:0] LEN_BUTTON = IW'(FRAME_LEN_BUTTON);
    localparam logic [IW-1:0] LEN_TOUCH  = IW'(FRAME_LEN_TOUCH);
    localparam logic [IW-1:0] LEN_STATE  = IW'(FRAME_LEN_STATE);
    localparam logic [IW-1:0] STORE_LIM  = IW'(STORE_DEPTH);

    // Type code registers
    logic [7:0] r_end_code;
    logic [7:0] r_click_code;
    logic [7:0] r_double_click_code;
    logic [7:0] r_press_start_code;
    logic [7:0] r_press_end_code;
    logic [7:0] r_touch_code;
    logic [7:0] r_button_state_code;

    // Input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;

    // Frame state
    logic [7:0]    r_store [STORE_DEPTH];
    logic [IW-1:0] r_wr_idx;
    logic [IW-1:0] n_wr_idx;
    logic [7:0]    r_button;
    logic [7:0]    n_button;
    logic [15:0]   r_x;
    logic [15:0]   n_x;
    logic [15:0]   r_y;
    logic [15:0]   n_y;
    logic [15:0]   r_mask;
    logic [15:0]   n_mask;

    // Result register (held values above are the rest of it)
    logic        r_out_valid;
    t_event_kind r_out_kind;
    t_event_kind n_kind;
    logic        r_out_err;
    logic        n_err;

    logic          advance;
    logic          proc;
    logic          is_end;
    logic [IW-1:0] idx_inc;
    t_event_kind   type_kind;
    logic [7:0]    fld_btn;
    logic [15:0]   fld_x_btn;
    logic [15:0]   fld_y_btn;
    logic [15:0]   fld_x_touch;
    logic [15:0]   fld_y_touch;
    logic [15:0]   mask_bit;

    assign advance    = !r_out_valid || o_evt.ready;
    assign proc       = r_in_valid && advance;
    assign i_rx.ready = !r_in_valid || advance;

    assign o_evt.valid       = r_out_valid;
    assign o_evt.event_kind  = r_out_kind;
    assign o_evt.btn_id      = r_button;
    assign o_evt.pos_x       = r_x;
    assign o_evt.pos_y       = r_y;
    assign o_evt.button_mask = r_mask;
    assign o_evt.index_error = r_out_err;

    // Field decode at fixed offsets; every offset read is below the current write slot
    // whenever the frame length matches, so no forwarding of the incoming byte is needed.
    assign fld_btn     = hex_field2(r_store[1], r_store[2]);
    assign fld_x_btn   = hex_field4(r_store[3], r_store[4], r_store[5], r_store[6]);
    assign fld_y_btn   = hex_field4(r_store[7], r_store[8], r_store[9], r_store[10]);
    assign fld_x_touch = hex_field4(r_store[1], r_store[2], r_store[3], r_store[4]);
    assign fld_y_touch = hex_field4(r_store[5], r_store[6], r_store[7], r_store[8]);
    assign mask_bit    = 16'(1) << fld_btn[3:0];

    assign idx_inc = (r_wr_idx == LAST_IDX) ? '0 : r_wr_idx + IW'(1);
    assign is_end  = (r_in_byte == r_end_code);

    // First match wins when codes are equal
    always_comb begin
        if (r_store[0] == r_click_code) begin
            type_kind = KIND_CLICK;
        end else if (r_store[0] == r_double_click_code) begin
            type_kind = KIND_DOUBLE_CLICK;
        end else if (r_store[0] == r_press_start_code) begin
            type_kind = KIND_PRESS_START;
        end else if (r_store[0] == r_press_end_code) begin
            type_kind = KIND_PRESS_END;
        end else if (r_store[0] == r_touch_code) begin
            type_kind = KIND_TOUCH;
        end else if (r_store[0] == r_button_state_code) begin
            type_kind = KIND_BUTTON_STATE;
        end else begin
            type_kind = KIND_NONE;
        end
    end

    always_comb begin
        n_wr_idx = idx_inc;
        n_kind   = KIND_NONE;
        n_err    = 1'b0;
        n_button = r_button;
        n_x      = r_x;
        n_y      = r_y;
        n_mask   = r_mask;
        if (is_end) begin
            n_wr_idx = '0;
            case (type_kind)
                KIND_CLICK, KIND_DOUBLE_CLICK, KIND_PRESS_START, KIND_PRESS_END: begin
                    if (idx_inc == LEN_BUTTON) begin
                        n_kind   = type_kind;
                        n_button = fld_btn;
                        n_x      = fld_x_btn;
                        n_y      = fld_y_btn;
                    end
                end
                KIND_TOUCH: begin
                    if (idx_inc == LEN_TOUCH) begin
                        n_kind = KIND_TOUCH;
                        n_x    = fld_x_touch;
                        n_y    = fld_y_touch;
                    end
                end
                KIND_BUTTON_STATE: begin
                    if (idx_inc == LEN_STATE) begin
                        n_kind   = KIND_BUTTON_STATE;
                        n_button = fld_btn;
                        if (fld_btn < 8'(BUTTONS)) begin
                            if (r_store[3] == STATE_ON_CHAR) begin
                                n_mask = r_mask | mask_bit;
                            end else begin
                                n_mask = r_mask & ~mask_bit;
                            end
                        end else begin
                            n_err = 1'b1;
                        end
                    end
                end
                default: begin
                    n_kind = KIND_NONE;
                end
            endcase
        end
    end

    // Configuration writes; indexes past the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_end_code          <= END_CODE_RST;
            r_click_code        <= CLICK_CODE_RST;
            r_double_click_code <= DOUBLE_CLICK_CODE_RST;
            r_press_start_code  <= PRESS_START_CODE_RST;
            r_press_end_code    <= PRESS_END_CODE_RST;
            r_touch_code        <= TOUCH_CODE_RST;
            r_button_state_code <= BUTTON_STATE_CODE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_END_CODE:          r_end_code          <= i_cfg_data;
                REG_CLICK_CODE:        r_click_code        <= i_cfg_data;
                REG_DOUBLE_CLICK_CODE: r_double_click_code <= i_cfg_data;
                REG_PRESS_START_CODE:  r_press_start_code  <= i_cfg_data;
                REG_PRESS_END_CODE:    r_press_end_code    <= i_cfg_data;
                REG_TOUCH_CODE:        r_touch_code        <= i_cfg_data;
                REG_BUTTON_STATE_CODE: r_button_state_code <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_wr_idx    <= '0;
            r_button    <= '0;
            r_x         <= '0;
            r_y         <= '0;
            r_mask      <= '0;
        end else begin
            if (i_rx.valid && i_rx.ready) begin
                r_in_valid <= 1'b1;
            end else if (proc) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
            if (proc) begin
                r_wr_idx <= n_wr_idx;
                r_button <= n_button;
                r_x      <= n_x;
                r_y      <= n_y;
                r_mask   <= n_mask;
            end
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (i_rx.valid && i_rx.ready) begin
            r_in_byte <= i_rx.rx_byte;
        end
        if (advance) begin
            r_out_kind <= n_kind;
            r_out_err  <= n_err;
        end
        // Offsets past the decoded span are never read, so they are not kept
        if (proc && (r_wr_idx < STORE_LIM)) begin
            r_store[r_wr_idx[SW-1:0]] <= r_in_byte;
        end
    end

`ifndef NO_ASSERTIONS
    a_err_only_on_state : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_err) |-> (r_out_kind == KIND_BUTTON_STATE))
        else $error("index error on a non button-state result");

    a_idx_clears_on_end : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (proc && is_end) |=> (r_wr_idx == '0))
        else $error("write index not cleared after end code");

    a_idx_in_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wr_idx <= LAST_IDX)
        else $error("write index out of range");

    a_mask_only_on_state : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(proc && (n_kind == KIND_BUTTON_STATE)) |=> $stable(r_mask))
        else $error("button mask changed outside a button-state frame");

    a_held_stable_on_stall : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_evt.ready) |=> ($stable(r_x) && $stable(r_y) && $stable(r_button)))
        else $error("held values changed while result stalled");
`endif

endmodule

`default_nettype wire
